// File: rtl/aadf_pkg.sv
`default_nettype none
package aadf_pkg;

	// field widths fixed by the interface
	localparam int ADDR_W  = 16;
	localparam int CNT_W   = 5;
	localparam int BYTE_W  = 8;
	localparam int CMD_W   = 2;

	localparam int DEFAULT_TABLE_ENTRIES = 16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

	// strobes broadcast to every cell of the row
	typedef struct packed {
		logic              add;
		logic              remove;
		logic              clear;
		logic [ADDR_W-1:0] addr;
	} chain_ctl_t;

endpackage
`default_nettype wire

// File: rtl/aadf_cell.sv
`default_nettype none
module aadf_cell (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire aadf_pkg::chain_ctl_t   ctl,
	input  wire                         found_any,
	input  wire                         match_in,
	input  wire                         left_valid,
	input  wire  [aadf_pkg::ADDR_W-1:0] nb_entry,
	input  wire                         nb_valid,
	output logic [aadf_pkg::ADDR_W-1:0] entry,
	output logic                        valid,
	output logic                        match_out
);

	logic [aadf_pkg::ADDR_W-1:0] entry_q;
	logic                        valid_q;
	logic                        match_here;
	logic                        take_nb;
	logic                        take_add;

	// compare the held word against the broadcast address
	assign match_here = valid_q && (entry_q == ctl.addr);
	assign match_out  = match_in | match_here;

	// on remove, every cell at or past the hit pulls its right neighbor
	assign take_nb  = ctl.remove && match_out;
	// on add, the first free cell takes the address unless it is already held
	assign take_add = ctl.add && !found_any && left_valid && !valid_q;

	// hold occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (take_nb) begin
			valid_q <= nb_valid;
		end else if (take_add) begin
			valid_q <= 1'b1;
		end
	end

	// hold the stored address
	always_ff @(posedge clk) begin
		if (take_nb) begin
			entry_q <= nb_entry;
		end else if (take_add) begin
			entry_q <= ctl.addr;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule
`default_nettype wire

// File: rtl/aadf_chain.sv
`default_nettype none
module aadf_chain #(
	parameter int TABLE_ENTRIES = aadf_pkg::DEFAULT_TABLE_ENTRIES,
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire aadf_pkg::chain_ctl_t   ctl,
	input  wire  [IDX_W-1:0]            rd_idx,
	output logic                        found,
	output logic [aadf_pkg::ADDR_W-1:0] rd_data
);

	logic [aadf_pkg::ADDR_W-1:0] entry_w [TABLE_ENTRIES];
	logic                        valid_w [TABLE_ENTRIES];
	logic                        match_w [TABLE_ENTRIES];

	// build the row; each cell links to its left and right neighbors
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		logic                        m_in;
		logic                        l_valid;
		logic [aadf_pkg::ADDR_W-1:0] r_entry;
		logic                        r_valid;

		if (i == 0) begin : g_first
			assign m_in    = 1'b0;
			assign l_valid = 1'b1;
		end else begin : g_mid
			assign m_in    = match_w[i-1];
			assign l_valid = valid_w[i-1];
		end

		if (i == TABLE_ENTRIES - 1) begin : g_last
			assign r_entry = '0;
			assign r_valid = 1'b0;
		end else begin : g_inner
			assign r_entry = entry_w[i+1];
			assign r_valid = valid_w[i+1];
		end

		aadf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.found_any  (found),
			.match_in   (m_in),
			.left_valid (l_valid),
			.nb_entry   (r_entry),
			.nb_valid   (r_valid),
			.entry      (entry_w[i]),
			.valid      (valid_w[i]),
			.match_out  (match_w[i])
		);
	end

	// the hit chain leaves the last cell as the overall hit
	assign found   = match_w[TABLE_ENTRIES-1];
	// dump read port
	assign rd_data = entry_w[rd_idx];

endmodule
`default_nettype wire

// File: rtl/address_allow_deny_filter.sv
// Latency: add, remove and check give their one result word the cycle after acceptance.
// Dump: the mode byte is registered in the cycle after acceptance, then one byte per cycle,
// paced only by out_ready; a dump of P pairs is 2*P+1 bytes long.
// Throughput: one add, remove or check per cycle while the output is drained and no mode write waits.
// Reset (arst_n low, asynchronous): list empty, allow-list mode, no output word pending.
`default_nettype none
module address_allow_deny_filter #(
	parameter int TABLE_ENTRIES = aadf_pkg::DEFAULT_TABLE_ENTRIES
) (
	input  wire                         clk,
	input  wire                         arst_n,

	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire                         filter_mode,

	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire  [aadf_pkg::CMD_W-1:0]  cmd,
	input  wire  [aadf_pkg::ADDR_W-1:0] address,
	input  wire  [aadf_pkg::BYTE_W-1:0] byte_limit,

	output logic                        out_valid,
	input  wire                         out_ready,
	output logic                        pass,
	output logic [aadf_pkg::BYTE_W-1:0] dump_byte,
	output logic                        last,
	output logic [aadf_pkg::BYTE_W-1:0] dump_length,
	output logic [aadf_pkg::CNT_W-1:0]  entry_count
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = aadf_pkg::CNT_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic                        st_q;
	logic                        mode_q;
	logic [CNT_W-1:0]            count_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        half_q;
	logic [CNT_W-1:0]            pairs_q;
	logic [aadf_pkg::BYTE_W-1:0] len_q;

	logic                        out_valid_q;
	logic                        pass_q;
	logic [aadf_pkg::BYTE_W-1:0] dump_byte_q;
	logic                        last_q;
	logic [aadf_pkg::BYTE_W-1:0] dump_length_q;
	logic [CNT_W-1:0]            entry_count_q;

	aadf_pkg::chain_ctl_t        ctl;
	logic                        found;
	logic [aadf_pkg::ADDR_W-1:0] rd_data;

	logic                        out_free;
	logic                        in_acc;
	logic                        cfg_acc;
	logic [CNT_W-1:0]            count_nxt;
	logic [6:0]                  lim_pairs;
	logic [CNT_W-1:0]            pairs;
	logic                        dump_last;

	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = (st_q == ST_IDLE);
	assign in_ready  = (st_q == ST_IDLE) && out_free && !cfg_valid;
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// broadcast the command to the row
	always_comb begin
		ctl.add    = in_acc && (cmd == aadf_pkg::CMD_ADD);
		ctl.remove = in_acc && (cmd == aadf_pkg::CMD_REMOVE);
		ctl.clear  = cfg_acc;
		ctl.addr   = address;
	end

	aadf_chain #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_idx  (idx_q),
		.found   (found),
		.rd_data (rd_data)
	);

	// count after the command
	always_comb begin
		count_nxt = count_q;
		case (cmd)
			aadf_pkg::CMD_ADD: begin
				if (!found && (count_q < FULL_CNT)) count_nxt = count_q + 1'b1;
			end
			aadf_pkg::CMD_REMOVE: begin
				if (found) count_nxt = count_q - 1'b1;
			end
			default: count_nxt = count_q;
		endcase
	end

	// number of address pairs that fit the byte limit behind the mode byte
	always_comb begin
		lim_pairs = (byte_limit == '0) ? 7'd0 : 7'((byte_limit - 8'd1) >> 1);
		pairs     = ({2'b00, count_q} < lim_pairs) ? count_q : CNT_W'(lim_pairs);
	end

	assign dump_last = half_q && ({{(CNT_W-IDX_W){1'b0}}, idx_q} == (pairs_q - 1'b1));

	// control: mode, count, dump sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			mode_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (cfg_acc) begin
				mode_q  <= filter_mode;
				count_q <= '0;
			end else if (in_acc) begin
				count_q <= count_nxt;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_acc && (cmd == aadf_pkg::CMD_DUMP) && (pairs != '0)) st_q <= ST_DUMP;
				end
				ST_DUMP: begin
					if (out_free && dump_last) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// dump position and length
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q   <= '0;
			half_q  <= 1'b0;
			pairs_q <= pairs;
			len_q   <= {2'b00, pairs, 1'b1};
		end else if ((st_q == ST_DUMP) && out_free) begin
			half_q <= !half_q;
			if (half_q) idx_q <= idx_q + 1'b1;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc || ((st_q == ST_DUMP) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			entry_count_q <= count_nxt;
			if (cmd == aadf_pkg::CMD_DUMP) begin
				pass_q        <= 1'b0;
				dump_byte_q   <= {7'd0, mode_q};
				last_q        <= (pairs == '0);
				dump_length_q <= (pairs == '0) ? 8'd1 : 8'd0;
			end else begin
				pass_q        <= (cmd == aadf_pkg::CMD_CHECK) && (found ^ mode_q);
				dump_byte_q   <= '0;
				last_q        <= 1'b1;
				dump_length_q <= '0;
			end
		end else if ((st_q == ST_DUMP) && out_free) begin
			pass_q        <= 1'b0;
			dump_byte_q   <= half_q ? rd_data[7:0] : rd_data[15:8];
			last_q        <= dump_last;
			dump_length_q <= dump_last ? len_q : 8'd0;
			entry_count_q <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pass        = pass_q;
	assign dump_byte   = dump_byte_q;
	assign last        = last_q;
	assign dump_length = dump_length_q;
	assign entry_count = entry_count_q;

endmodule
`default_nettype wire

// File: rtl/aadf_checker.sv
`default_nettype none
module aadf_checker #(
	parameter int TABLE_ENTRIES = aadf_pkg::DEFAULT_TABLE_ENTRIES
) (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         out_valid,
	input wire                         out_ready,
	input wire                         pass,
	input wire [aadf_pkg::BYTE_W-1:0]  dump_byte,
	input wire                         last,
	input wire [aadf_pkg::BYTE_W-1:0]  dump_length,
	input wire [aadf_pkg::CNT_W-1:0]   entry_count
);

	// a stalled word stays valid and keeps its dump byte and last flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dump_byte) && $stable(last))
		else $error("output word changed while stalled");

	// a check verdict is always a single-word result
	a_pass_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pass |-> last && (dump_length == '0))
		else $error("pass set on a non-final word");

	// length only appears on the final word
	a_len_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> (dump_length == '0))
		else $error("dump length on a non-final word");

	// a dump length is mode byte plus whole pairs
	a_len_odd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (dump_length != '0) |-> dump_length[0])
		else $error("dump length even");

	// occupancy never exceeds the table
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= aadf_pkg::CNT_W'(TABLE_ENTRIES)))
		else $error("entry count above table size");

endmodule

bind address_allow_deny_filter aadf_checker #(
	.TABLE_ENTRIES (TABLE_ENTRIES)
) u_aadf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pass        (pass),
	.dump_byte   (dump_byte),
	.last        (last),
	.dump_length (dump_length),
	.entry_count (entry_count)
);
`default_nettype wire

// File: sim/address_allow_deny_filter_test.sv
`default_nettype none
module address_allow_deny_filter_test;
	import aadf_pkg::*;

	localparam int DEPTH = DEFAULT_TABLE_ENTRIES;
	localparam bit MODE_ALLOW = 1'b0;
	localparam bit MODE_DENY  = 1'b1;
	localparam int POOL_SIZE  = 24;

	typedef struct packed {
		logic              pass;
		logic [BYTE_W-1:0] dump_byte;
		logic              last;
		logic [BYTE_W-1:0] dump_length;
		logic [CNT_W-1:0]  entry_count;
	} result_word_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              filter_mode;
	logic              in_valid;
	logic              in_ready;
	logic [CMD_W-1:0]  cmd;
	logic [ADDR_W-1:0] address;
	logic [BYTE_W-1:0] byte_limit;
	logic              out_valid;
	logic              out_ready;
	logic              pass;
	logic [BYTE_W-1:0] dump_byte;
	logic              last;
	logic [BYTE_W-1:0] dump_length;
	logic [CNT_W-1:0]  entry_count;

	// filter state as the testbench sees it
	logic [ADDR_W-1:0] held_addr [DEPTH];
	int                held_len;
	bit                mode_q;

	result_word_t      expected_words [$];
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
	int                error_count;
	bit                quiet;

	address_allow_deny_filter DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.filter_mode (filter_mode),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.address     (address),
		.byte_limit  (byte_limit),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pass        (pass),
		.dump_byte   (dump_byte),
		.last        (last),
		.dump_length (dump_length),
		.entry_count (entry_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int find_addr(logic [ADDR_W-1:0] a);
		for (int i = 0; i < held_len; i++)
			if (held_addr[i] == a)
				return i;
		return -1;
	endfunction

	function automatic void push_word(logic p, logic [BYTE_W-1:0] b, logic l,
			logic [BYTE_W-1:0] len);
		result_word_t w;
		w.pass        = p;
		w.dump_byte   = b;
		w.last        = l;
		w.dump_length = len;
		w.entry_count = held_len[CNT_W-1:0];
		expected_words.push_back(w);
	endfunction

	// update the list and queue the words one command produces
	function automatic void predict_command(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
			logic [BYTE_W-1:0] lim);
		int pos;
		int pairs;
		int total;
		pos = find_addr(a);
		case (c)
			CMD_ADD: begin
				if (pos < 0 && held_len < DEPTH) begin
					held_addr[held_len] = a;
					held_len++;
				end
				push_word(1'b0, '0, 1'b1, '0);
			end
			CMD_REMOVE: begin
				if (pos >= 0) begin
					held_len--;
					for (int i = pos; i < held_len; i++)
						held_addr[i] = held_addr[i + 1];
				end
				push_word(1'b0, '0, 1'b1, '0);
			end
			CMD_CHECK: begin
				push_word((mode_q == MODE_ALLOW) ? (pos >= 0) : (pos < 0), '0, 1'b1, '0);
			end
			default: begin
				pairs = 0;
				while (pairs < held_len && 2 * pairs + 3 <= int'(lim))
					pairs++;
				total = 2 * pairs + 1;
				push_word(1'b0, {7'b0, mode_q}, pairs == 0, (pairs == 0) ? 8'd1 : 8'd0);
				for (int i = 0; i < pairs; i++) begin
					push_word(1'b0, held_addr[i][15:8], 1'b0, '0);
					push_word(1'b0, held_addr[i][7:0], i == pairs - 1,
						(i == pairs - 1) ? total[BYTE_W-1:0] : 8'd0);
				end
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- drivers

	// present one command word, leave valid high after acceptance
	task automatic send_word(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
			logic [BYTE_W-1:0] lim);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		address    <= a;
		byte_limit <= lim;
		do @(posedge clk); while (!in_ready);
		predict_command(c, a, lim);
	endtask

	// drop valid and hold until every queued word has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_mode(bit m);
		wait_drained();
		cfg_valid   <= 1'b1;
		filter_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mode_q    = m;
		held_len  = 0;
	endtask

	function automatic logic [BYTE_W-1:0] random_limit();
		return BYTE_W'($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 255));
	endfunction

	function automatic logic [ADDR_W-1:0] random_addr();
		return ADDR_W'($urandom_range(0, 65535));
	endfunction

	// ---------------------------------------------------------------- response side

	// stall the result side in bursts
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			error_count++;
		end
	endtask

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		result_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected result word: dump_byte %0d last %0d", dump_byte, last);
				error_count++;
			end else begin
				w = expected_words.pop_front();
				check_field("pass", w.pass, pass);
				check_field("dump_byte", w.dump_byte, dump_byte);
				check_field("last", w.last, last);
				check_field("dump_length", w.dump_length, dump_length);
				check_field("entry_count", w.entry_count, entry_count);
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// reset state: empty allow list
	task automatic test_empty_list();
		send_word(CMD_CHECK, 16'h0000, 8'h00);
		send_word(CMD_DUMP, 16'hFFFF, 8'h00);
		send_word(CMD_REMOVE, 16'hFFFF, 8'hFF);
	endtask

	task automatic test_add_remove_check();
		send_word(CMD_ADD, 16'hFFFF, 8'h00);
		send_word(CMD_ADD, 16'h0000, 8'h00);
		send_word(CMD_ADD, 16'hFFFF, 8'h00);
		send_word(CMD_CHECK, 16'hFFFF, 8'h00);
		send_word(CMD_CHECK, 16'h1234, 8'h00);
		send_word(CMD_DUMP, 16'h0000, 8'hFF);
		send_word(CMD_DUMP, 16'h0000, 8'd2);
		send_word(CMD_DUMP, 16'h0000, 8'd3);
		send_word(CMD_REMOVE, 16'h1234, 8'h00);
		send_word(CMD_REMOVE, 16'hFFFF, 8'h00);
		send_word(CMD_CHECK, 16'h0000, 8'h00);
		send_word(CMD_DUMP, 16'h0000, 8'hFF);
	endtask

	// mode write empties the list and inverts the verdict
	task automatic test_deny_mode();
		write_mode(MODE_DENY);
		send_word(CMD_CHECK, 16'h0000, 8'h00);
		send_word(CMD_ADD, 16'hA5A5, 8'h00);
		send_word(CMD_CHECK, 16'hA5A5, 8'h00);
		send_word(CMD_CHECK, 16'h5A5A, 8'h00);
		send_word(CMD_DUMP, 16'h0000, 8'hFF);
	endtask

	// fill to capacity, add past it, then remove first, middle and last
	task automatic test_fill_to_capacity();
		int k;
		write_mode(MODE_ALLOW);
		send_word(CMD_CHECK, 16'hA5A5, random_limit());
		while (held_len < DEPTH)
			send_word(CMD_ADD, random_addr(), random_limit());
		send_word(CMD_ADD, held_addr[3], random_limit());
		send_word(CMD_ADD, random_addr(), random_limit());
		send_word(CMD_DUMP, random_addr(), 8'hFF);
		k = $urandom_range(1, DEPTH);
		send_word(CMD_DUMP, random_addr(), BYTE_W'(2 * k + 1));
		send_word(CMD_DUMP, random_addr(), BYTE_W'(2 * k));
		send_word(CMD_CHECK, held_addr[DEPTH - 1], random_limit());
		send_word(CMD_REMOVE, held_addr[0], random_limit());
		send_word(CMD_REMOVE, held_addr[held_len / 2], random_limit());
		send_word(CMD_REMOVE, held_addr[held_len - 1], random_limit());
		send_word(CMD_DUMP, random_addr(), 8'hFF);
	endtask

	// mixed commands over a small address pool so hits are common
	task automatic test_random_traffic(bit m, int n);
		int r;
		logic [CMD_W-1:0]  c;
		logic [ADDR_W-1:0] a;
		write_mode(m);
		foreach (addr_pool[i])
			addr_pool[i] = random_addr();
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				c = CMD_ADD;
			else if (r < 55)
				c = CMD_REMOVE;
			else if (r < 85)
				c = CMD_CHECK;
			else
				c = CMD_DUMP;
			if ($urandom_range(0, 9) < 7)
				a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				a = random_addr();
			send_word(c, a, random_limit());
		end
	endtask

	// ---------------------------------------------------------------- run

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		filter_mode = 1'b0;
		in_valid    = 1'b0;
		cmd         = CMD_ADD;
		address     = '0;
		byte_limit  = '0;
		error_count = 0;
		quiet       = 1'b0;
		held_len    = 0;
		mode_q      = MODE_ALLOW;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_add_remove_check();
		test_deny_mode();
		test_fill_to_capacity();
		test_random_traffic(MODE_DENY, 90);
		test_random_traffic(MODE_ALLOW, 70);
		quiet = 1'b1;
		test_random_traffic(MODE_DENY, 70);

		wait_drained();
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// stop a hung run
	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
rtl/aadf_pkg.sv
rtl/aadf_cell.sv
rtl/aadf_chain.sv
rtl/address_allow_deny_filter.sv
rtl/aadf_checker.sv
sim/address_allow_deny_filter_test.sv
